[design/affine_vertex_transform_defines.svh]
// Assertion macros shared by the design files.
`ifndef AFFINE_VERTEX_TRANSFORM_DEFINES_SVH
`define AFFINE_VERTEX_TRANSFORM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define AVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

[design/avt_pkg.sv]
package avt_pkg;

   typedef logic [2:0]         mode_type;
   typedef logic signed [31:0] q_type;
   typedef logic signed [63:0] wide_type;

   localparam mode_type MODE_LOAD  = 3'd0;
   localparam mode_type MODE_BUILD = 3'd1;
   localparam mode_type MODE_POINT = 3'd2;
   localparam mode_type MODE_DIR   = 3'd3;
   localparam mode_type MODE_HOMOG = 3'd4;

   localparam int MATRIX_DEPTH = 16;
   localparam int NUM_MULT     = 12;

   localparam wide_type Q_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam wide_type Q_MIN = 64'shFFFF_FFFF_8000_0000;

   function automatic q_type sat_q(input wide_type value);
      q_type result;
      if (value > Q_MAX) begin
         result = 32'sh7FFF_FFFF;
      end else if (value < Q_MIN) begin
         result = 32'sh8000_0000;
      end else begin
         result = value[31:0];
      end
      return result;
   endfunction

   function automatic wide_type sext_q(input q_type value);
      return {{32{value[31]}}, value};
   endfunction

   function automatic logic is_transform(input mode_type mode);
      return (mode == MODE_POINT) || (mode == MODE_DIR) || (mode == MODE_HOMOG);
   endfunction

endpackage

[design/affine_vertex_transform.sv]
// Holds a 4x4 matrix of signed fixed-point values with FRAC_BITS fraction bits (Q16.16 by
// default, element at row*4+column, cleared by reset) and per item either loads one element,
// rebuilds the matrix from a quaternion and a position, or transforms a vector as a point,
// a direction or a homogeneous point. Each accepted item sits in an input register, passes
// through twelve parallel 32x32 multipliers with truncating shifts, adder trees and
// saturation, and lands in the result register; one item is taken every
// cycle as long as the result side is not stalling, and load or build items give no transfer
// on the result channel. A matrix change takes effect for the item that follows it directly.
`include "affine_vertex_transform_defines.svh"

module affine_vertex_transform
   import avt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_element_index,
   input  logic signed [31:0] req_element_value,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_quat_yz_part,
   input  logic signed [31:0] req_quat_zx_part,
   input  logic signed [31:0] req_quat_xy_part,
   input  logic signed [31:0] req_quat_scalar,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [31:0] rsp_out_w
);

   localparam q_type ONE_Q = 32'sd1 <<< FRAC_BITS;

   localparam int P_WW = 0;
   localparam int P_XX = 1;
   localparam int P_YY = 2;
   localparam int P_ZZ = 3;
   localparam int P_WX = 4;
   localparam int P_WY = 5;
   localparam int P_WZ = 6;
   localparam int P_XY = 7;
   localparam int P_XZ = 8;
   localparam int P_YZ = 9;

   logic     stage_valid_ff, stage_valid_in;
   mode_type stage_mode_ff;
   logic [3:0] stage_index_ff;
   q_type    stage_value_ff;
   q_type    stage_vec_ff [3];
   q_type    stage_qx_ff, stage_qy_ff, stage_qz_ff, stage_qw_ff;

   q_type    matrix_ff [MATRIX_DEPTH];
   q_type    matrix_in [MATRIX_DEPTH];

   logic     rsp_valid_ff, rsp_valid_in;
   q_type    out_x_ff, out_y_ff, out_z_ff, out_w_ff;

   logic     req_accept;
   logic     rsp_free;
   logic     stage_xform;
   logic     stage_advance;
   logic     rsp_load;
   logic     use_trans;

   q_type    op_a [NUM_MULT];
   q_type    op_b [NUM_MULT];
   wide_type prod [NUM_MULT];
   wide_type row_sum [4];

   assign stage_xform   = stage_valid_ff && is_transform(stage_mode_ff);
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign stage_advance = stage_valid_ff && (!is_transform(stage_mode_ff) || rsp_free);
   assign req_stall     = stage_valid_ff && !stage_advance;
   assign req_accept    = req_valid && !req_stall;
   assign rsp_load      = stage_advance && stage_xform;
   assign use_trans     = (stage_mode_ff != MODE_DIR);

   assign stage_valid_in = req_accept || (stage_valid_ff && !stage_advance);
   assign rsp_valid_in   = rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            op_a[r*3 + c] = stage_vec_ff[c];
            op_b[r*3 + c] = matrix_ff[r*4 + c];
         end
      end
      if (stage_mode_ff == MODE_BUILD) begin
         op_a[P_WW] = stage_qw_ff;  op_b[P_WW] = stage_qw_ff;
         op_a[P_XX] = stage_qx_ff;  op_b[P_XX] = stage_qx_ff;
         op_a[P_YY] = stage_qy_ff;  op_b[P_YY] = stage_qy_ff;
         op_a[P_ZZ] = stage_qz_ff;  op_b[P_ZZ] = stage_qz_ff;
         op_a[P_WX] = stage_qw_ff;  op_b[P_WX] = stage_qx_ff;
         op_a[P_WY] = stage_qw_ff;  op_b[P_WY] = stage_qy_ff;
         op_a[P_WZ] = stage_qw_ff;  op_b[P_WZ] = stage_qz_ff;
         op_a[P_XY] = stage_qx_ff;  op_b[P_XY] = stage_qy_ff;
         op_a[P_XZ] = stage_qx_ff;  op_b[P_XZ] = stage_qz_ff;
         op_a[P_YZ] = stage_qy_ff;  op_b[P_YZ] = stage_qz_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_MULT; i++) begin
         prod[i] = (sext_q(op_a[i]) * sext_q(op_b[i])) >>> FRAC_BITS;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         row_sum[r] = prod[r*3] + prod[r*3 + 1] + prod[r*3 + 2]
                    + (use_trans ? sext_q(matrix_ff[r*4 + 3]) : '0);
      end
   end

   always_comb begin
      matrix_in = matrix_ff;
      if (stage_advance) begin
         unique case (stage_mode_ff)
            MODE_LOAD: begin
               matrix_in[stage_index_ff] = stage_value_ff;
            end
            MODE_BUILD: begin
               matrix_in[0]  = sat_q(prod[P_WW] + prod[P_XX] - prod[P_YY] - prod[P_ZZ]);
               matrix_in[4]  = sat_q((prod[P_WZ] <<< 1) + (prod[P_XY] <<< 1));
               matrix_in[8]  = sat_q((prod[P_XZ] <<< 1) - (prod[P_WY] <<< 1));
               matrix_in[12] = '0;
               matrix_in[1]  = sat_q((prod[P_XY] <<< 1) - (prod[P_WZ] <<< 1));
               matrix_in[5]  = sat_q(prod[P_WW] - prod[P_XX] + prod[P_YY] - prod[P_ZZ]);
               matrix_in[9]  = sat_q((prod[P_WX] <<< 1) + (prod[P_YZ] <<< 1));
               matrix_in[13] = '0;
               matrix_in[2]  = sat_q((prod[P_WY] <<< 1) + (prod[P_XZ] <<< 1));
               matrix_in[6]  = sat_q((prod[P_YZ] <<< 1) - (prod[P_WX] <<< 1));
               matrix_in[10] = sat_q(prod[P_WW] - prod[P_XX] - prod[P_YY] + prod[P_ZZ]);
               matrix_in[14] = '0;
               matrix_in[3]  = stage_vec_ff[0];
               matrix_in[7]  = stage_vec_ff[1];
               matrix_in[11] = stage_vec_ff[2];
               matrix_in[15] = ONE_Q;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MATRIX_DEPTH; i++) begin
            matrix_ff[i] <= '0;
         end
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         matrix_ff      <= matrix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_mode_ff   <= req_mode;
         stage_index_ff  <= req_element_index;
         stage_value_ff  <= req_element_value;
         stage_vec_ff[0] <= req_vec_x;
         stage_vec_ff[1] <= req_vec_y;
         stage_vec_ff[2] <= req_vec_z;
         stage_qx_ff     <= req_quat_yz_part;
         stage_qy_ff     <= req_quat_zx_part;
         stage_qz_ff     <= req_quat_xy_part;
         stage_qw_ff     <= req_quat_scalar;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_x_ff <= sat_q(row_sum[0]);
         out_y_ff <= sat_q(row_sum[1]);
         out_z_ff <= sat_q(row_sum[2]);
         out_w_ff <= (stage_mode_ff == MODE_HOMOG) ? sat_q(row_sum[3]) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_z = out_z_ff;
   assign rsp_out_w = out_w_ff;

   `AVT_ASSERT_SAME(a_nonresult_never_stalls, clock, reset, stage_valid_ff && !stage_xform, !req_stall)
   `AVT_ASSERT_SAME(a_result_only_from_transform, clock, reset, rsp_load, is_transform(stage_mode_ff))
   `AVT_ASSERT_NEXT(a_load_writes_element, clock, reset, stage_advance && (stage_mode_ff == MODE_LOAD), matrix_ff[$past(stage_index_ff)] == $past(stage_value_ff))
   `AVT_ASSERT_NEXT(a_w_zero_unless_homog, clock, reset, rsp_load && (stage_mode_ff != MODE_HOMOG), rsp_out_w == 32'sd0)

endmodule
